// ===== rtl/u16550_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types, constants and helpers for the 16550-style UART register block.
// ----------------------------------------------------------------------------
package u16550_pkg;

    // FIFO geometry
    localparam int QDEPTH = 16;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Stream widths
    localparam int S_DATA_W = 16;  // offset(3) + data(8), padded to bytes
    localparam int S_USER_W = 2;   // kind
    localparam int M_DATA_W = 16;  // read_data(8) + 3 flags, padded to bytes

    // Item kinds
    typedef enum logic [1:0] {
        KIND_BUS_READ  = 2'd0,
        KIND_BUS_WRITE = 2'd1,
        KIND_HOST_RX   = 2'd2,
        KIND_HOST_PULL = 2'd3
    } kind_t;

    // Register offsets
    localparam logic [2:0] OFF_DATA = 3'd0;  // RBR / THR / DLL
    localparam logic [2:0] OFF_IER  = 3'd1;  // IER / DLM
    localparam logic [2:0] OFF_IIR  = 3'd2;  // IIR / FCR
    localparam logic [2:0] OFF_LCR  = 3'd3;
    localparam logic [2:0] OFF_MCR  = 3'd4;
    localparam logic [2:0] OFF_LSR  = 3'd5;

    // Register bits and codes
    localparam int         IER_RX_BIT   = 0;
    localparam int         IER_TX_BIT   = 1;
    localparam int         LCR_DLAB_BIT = 7;
    localparam logic [7:0] LCR_RESET    = 8'h03;
    localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
    localparam logic [7:0] IIR_NO_INT   = 8'h01;
    localparam logic [7:0] IIR_RX_DATA  = 8'h04;
    localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
    localparam logic [7:0] LSR_BASE     = 8'h60;
    localparam logic [7:0] LSR_DR       = 8'h01;

    // Source of the read data for a result
    typedef enum logic [1:0] {
        SRC_REG = 2'd0,
        SRC_RX  = 2'd1,
        SRC_TX  = 2'd2
    } rd_src_t;

    // Controller state
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic finish;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
    } status_t;

    // Circular pointer advance
    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        ptr_inc = (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/u16550_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16550_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module u16550_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/u16550_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16550_ctrl
// Sequencer: accept an item, execute it, then hand the result to the output.
// ----------------------------------------------------------------------------
module u16550_ctrl
    import u16550_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/u16550_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16550_dp
// Register file, FIFO pointers and RAMs, and the output register.
// ----------------------------------------------------------------------------
module u16550_dp
    import u16550_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [2:0] offset, [10:3] data
    input  wire logic [S_USER_W-1:0] s_tuser,   // [1:0] kind
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // [7:0] read_data, [8] interrupt,
                                                // [9] tx_waiting, [10] dropped
    input  wire cmd_t                cmd,
    output status_t                  status
);

    // Item registers
    kind_t      kind_reg;
    logic [2:0] off_reg;
    logic [7:0] data_reg;

    // UART registers
    logic [7:0] ier_reg, ier_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic       txflag_reg, txflag_next;
    logic       fen_reg, fen_next;

    // FIFO bookkeeping
    logic [QAW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [QAW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [QCW-1:0] rx_count_reg, rx_count_next, tx_count_reg, tx_count_next;

    // Per-item results
    logic [7:0] rd_pre_reg, rd_pre_next;
    rd_src_t    src_reg, src_next;
    logic       drop_reg, drop_next;

    // Output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // RAM strobes
    logic       rx_we, tx_we;
    logic [7:0] rx_q, tx_q;

    logic dlab, rx_nonempty, rx_full, tx_full, rx_irq, tx_irq, irq_now;

    assign dlab        = lcr_reg[LCR_DLAB_BIT];
    assign rx_nonempty = (rx_count_reg != '0);
    assign rx_full     = (rx_count_reg == QCW'(QDEPTH));
    assign tx_full     = (tx_count_reg == QCW'(QDEPTH));
    assign rx_irq      = rx_nonempty && ier_reg[IER_RX_BIT];
    assign tx_irq      = ier_reg[IER_TX_BIT] && txflag_reg;
    assign irq_now     = rx_irq || tx_irq;

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= kind_t'(s_tuser[1:0]);
            off_reg  <= s_tdata[2:0];
            data_reg <= s_tdata[10:3];
        end
    end

    // Execute one item
    always_comb begin
        ier_next      = ier_reg;
        lcr_next      = lcr_reg;
        mcr_next      = mcr_reg;
        dll_next      = dll_reg;
        dlm_next      = dlm_reg;
        txflag_next   = txflag_reg;
        fen_next      = fen_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_count_next = rx_count_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_count_next = tx_count_reg;
        rd_pre_next   = '0;
        src_next      = SRC_REG;
        drop_next     = 1'b0;
        rx_we         = 1'b0;
        tx_we         = 1'b0;
        if (cmd.exec) begin
            unique case (kind_reg)
                KIND_BUS_READ: begin
                    if (dlab && off_reg == OFF_DATA) begin
                        rd_pre_next = dll_reg;
                    end else if (dlab && off_reg == OFF_IER) begin
                        rd_pre_next = dlm_reg;
                    end else begin
                        unique case (off_reg)
                            OFF_DATA: begin
                                if (rx_nonempty) begin
                                    src_next      = SRC_RX;
                                    rx_head_next  = ptr_inc(rx_head_reg);
                                    rx_count_next = rx_count_reg - QCW'(1);
                                end
                            end
                            OFF_IER: rd_pre_next = ier_reg;
                            OFF_IIR: begin
                                rd_pre_next = (fen_reg ? IIR_FIFO_ON : 8'h00)
                                            | (irq_now ? 8'h00 : IIR_NO_INT)
                                            | (rx_irq ? IIR_RX_DATA
                                               : (tx_irq ? IIR_TX_EMPTY : 8'h00));
                                txflag_next = 1'b0;
                            end
                            OFF_LCR: rd_pre_next = lcr_reg;
                            OFF_MCR: rd_pre_next = mcr_reg;
                            OFF_LSR: rd_pre_next = LSR_BASE
                                                 | (rx_nonempty ? LSR_DR : 8'h00);
                            default: rd_pre_next = '0;
                        endcase
                    end
                end
                KIND_BUS_WRITE: begin
                    if (dlab && off_reg == OFF_DATA) begin
                        dll_next = data_reg;
                    end else if (dlab && off_reg == OFF_IER) begin
                        dlm_next = data_reg;
                    end else begin
                        unique case (off_reg)
                            OFF_DATA: begin
                                txflag_next = ier_reg[IER_TX_BIT];
                                if (tx_full) begin
                                    drop_next = 1'b1;
                                end else begin
                                    tx_we         = 1'b1;
                                    tx_tail_next  = ptr_inc(tx_tail_reg);
                                    tx_count_next = tx_count_reg + QCW'(1);
                                end
                            end
                            OFF_IER: ier_next = data_reg;
                            OFF_IIR: fen_next = data_reg[0];
                            OFF_LCR: lcr_next = data_reg;
                            OFF_MCR: mcr_next = data_reg;
                            default: ;
                        endcase
                    end
                end
                KIND_HOST_RX: begin
                    if (rx_full) begin
                        drop_next = 1'b1;
                    end else begin
                        rx_we         = 1'b1;
                        rx_tail_next  = ptr_inc(rx_tail_reg);
                        rx_count_next = rx_count_reg + QCW'(1);
                    end
                end
                KIND_HOST_PULL: begin
                    if (tx_count_reg != '0) begin
                        src_next      = SRC_TX;
                        tx_head_next  = ptr_inc(tx_head_reg);
                        tx_count_next = tx_count_reg - QCW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ier_reg      <= '0;
            lcr_reg      <= LCR_RESET;
            mcr_reg      <= '0;
            dll_reg      <= '0;
            dlm_reg      <= '0;
            txflag_reg   <= 1'b0;
            fen_reg      <= 1'b0;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            rx_count_reg <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_count_reg <= '0;
        end else begin
            ier_reg      <= ier_next;
            lcr_reg      <= lcr_next;
            mcr_reg      <= mcr_next;
            dll_reg      <= dll_next;
            dlm_reg      <= dlm_next;
            txflag_reg   <= txflag_next;
            fen_reg      <= fen_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_count_reg <= rx_count_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_count_reg <= tx_count_next;
        end
    end

    // Per-item results, held until the result is formed
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rd_pre_reg <= rd_pre_next;
            src_reg    <= src_next;
            drop_reg   <= drop_next;
        end
    end

    // FIFO storage; head entry is read during execute
    u16550_ram #(.WIDTH(8), .DEPTH(QDEPTH)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_tail_reg),
        .wdata (data_reg),
        .re    (cmd.exec),
        .raddr (rx_head_reg),
        .rdata (rx_q)
    );

    u16550_ram #(.WIDTH(8), .DEPTH(QDEPTH)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_tail_reg),
        .wdata (data_reg),
        .re    (cmd.exec),
        .raddr (tx_head_reg),
        .rdata (tx_q)
    );

    // Result assembly; flags reflect state after the item
    logic [7:0] rd_final;
    always_comb begin
        unique case (src_reg)
            SRC_RX:  rd_final = rx_q;
            SRC_TX:  rd_final = tx_q;
            default: rd_final = rd_pre_reg;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= {5'b0, drop_reg, (tx_count_reg != '0), irq_now, rd_final};
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    // Checks
    a_rx_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= QCW'(QDEPTH))
        else $error("rx count above depth");

    a_tx_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_count_reg <= QCW'(QDEPTH))
        else $error("tx count above depth");

    a_counts_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> $stable(rx_count_reg) && $stable(tx_count_reg))
        else $error("fifo count moved outside execute");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && drop_next |-> rx_full || tx_full)
        else $error("drop without a full fifo");

endmodule
`default_nettype wire

// ===== rtl/uart_16550_register_model.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: each item is accepted, executed (with the FIFO RAM read) and its result
//   loaded into the output register that drives m_tvalid; no new item is accepted
//   before that load, and the load waits while the output holds an untaken result.
// Reset: aresetn low synchronously clears registers to their defaults (LCR = 0x03)
//   and empties both FIFOs; FIFO RAM contents are not cleared.
// ----------------------------------------------------------------------------
// uart_16550_register_model
// Register face of a simplified 16550 UART with receive and transmit FIFOs.
// ----------------------------------------------------------------------------
module uart_16550_register_model
    import u16550_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [2:0] offset, [10:3] data
    input  wire logic [S_USER_W-1:0] s_tuser,   // [1:0] kind
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata    // [7:0] read_data, [8] interrupt,
                                                // [9] tx_waiting, [10] dropped
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    u16550_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, FIFOs and output stage
    u16550_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
`default_nettype wire
